### hw/rtl/assert_macros.svh
// assertion macros of the flow hash block, used by symmetric_flow_hash.sv
// depends on nothing; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// fixed delay check: cons must hold at the delay given by lat after ante
`define ASSERT_DELAY(name, clk, rst_n, ante, lat, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error("latency check failed");

`endif

### hw/rtl/sfh_pkg.sv
// types, constants and byte swap helpers of the symmetric flow hash
// depends on nothing; used by every rtl module of the block
`default_nettype none

package sfh_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned HashW    = 64;
    localparam int unsigned LabelMax = 10;
    localparam int unsigned CountW   = 4;

    localparam logic [HashW-1:0] HashSeed = 64'd1125899906842597;

    // label lengths in words
    localparam logic [CountW-1:0] LabelNone = 4'd2;
    localparam logic [CountW-1:0] LabelIpv4 = 4'd4;
    localparam logic [CountW-1:0] LabelIpv6 = 4'd10;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_IPV4 = 2'd1,
        KIND_IPV6 = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_UNDET     = 2'd0,
        DIR_SRC_LEFT  = 2'd1,
        DIR_SRC_RIGHT = 2'd2
    } dir_t;

    typedef logic [LabelMax-1:0][WordW-1:0] label_t;

    // one pipeline slot: the label still to fold sits from word 0 upward
    typedef struct packed {
        logic              vld;
        dir_t              dir;
        logic [CountW-1:0] n;
        logic [CountW-1:0] rem;
        label_t            words;
        logic [HashW-1:0]  hash;
    } fold_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/symmetric_flow_hash.sv
// top level of the symmetric five-tuple flow hash
// depends on sfh_pkg, sfh_order, sfh_fold and assert_macros.svh
//
// channel   signals                                     transfer when
// --------  ------------------------------------------  -------------------------
// command   start, busy, addr_kind .. protocol          start high, busy low
// result    done, direction, flow_hash, label_words     done high (one cycle)
//
// an item enters every cycle; busy is held low because nothing in the
// pipeline can back up. one stage does the endpoint compare and label
// assembly, then ten hash stages fold one label word each (short labels
// pass the spare stages unchanged); done comes from the last hash stage
// register, and each result is shown for one cycle only. reset clears
// every stage register; there are no stalls on either side.
`default_nettype none

`include "assert_macros.svh"

module symmetric_flow_hash
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  addr_kind,
    input  wire logic [63:0] src_addr_high,
    input  wire logic [63:0] src_addr_low,
    input  wire logic [63:0] dst_addr_high,
    input  wire logic [63:0] dst_addr_low,
    input  wire logic        has_ports,
    input  wire logic [15:0] sport,
    input  wire logic [15:0] dport,
    input  wire logic [7:0]  protocol,
    output logic             done,
    output logic [1:0]       direction,
    output logic [63:0]      flow_hash,
    output logic [3:0]       label_words
);

    // slot 0 is the order stage output, slot k the output of hash stage k
    sfh_pkg::fold_t slot [sfh_pkg::LabelMax+1];
    logic           accept;
    logic           len_ok;

    // never busy: the pipeline moves every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    sfh_order u_order
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .vld_in        (accept),
        .addr_kind     (addr_kind),
        .src_addr_high (src_addr_high),
        .src_addr_low  (src_addr_low),
        .dst_addr_high (dst_addr_high),
        .dst_addr_low  (dst_addr_low),
        .has_ports     (has_ports),
        .sport         (sport),
        .dport         (dport),
        .protocol      (protocol),
        .slot          (slot[0])
    );

    // one hash stage per label word of the longest (ipv6) label
    for (genvar k = 0; k < sfh_pkg::LabelMax; k++)
    begin : g_fold
        sfh_fold u_fold
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_in  (slot[k]),
            .slot_out (slot[k+1])
        );
    end

    // the last stage register doubles as the result register
    assign done        = slot[sfh_pkg::LabelMax].vld;
    assign direction   = slot[sfh_pkg::LabelMax].dir;
    assign flow_hash   = slot[sfh_pkg::LabelMax].hash;
    assign label_words = slot[sfh_pkg::LabelMax].n;

    // label length follows the address kind: 2, 4 or 10 words
    assign len_ok = (label_words == sfh_pkg::LabelNone) ||
                    (label_words == sfh_pkg::LabelIpv4) ||
                    (label_words == sfh_pkg::LabelIpv6);

    // every transfer in gives a result once it has passed the order stage and all hash stages
    `ASSERT_DELAY(a_latency, clk, rst_n, accept, 11, done)

    // by the end of the pipe the whole label has been folded in
    `ASSERT_IMPLY(a_label_used, clk, rst_n, done, slot[sfh_pkg::LabelMax].rem == 4'd0)

    `ASSERT_IMPLY(a_label_len, clk, rst_n, done, len_ok)

endmodule

`default_nettype wire

### hw/rtl/sfh_order.sv
// first stage: endpoint compare, direction and label assembly
// depends on sfh_pkg
`default_nettype none

module sfh_order
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vld_in,
    input  wire logic [1:0]            addr_kind,
    input  wire logic [63:0]           src_addr_high,
    input  wire logic [63:0]           src_addr_low,
    input  wire logic [63:0]           dst_addr_high,
    input  wire logic [63:0]           dst_addr_low,
    input  wire logic                  has_ports,
    input  wire logic [15:0]           sport,
    input  wire logic [15:0]           dport,
    input  wire logic [7:0]            protocol,
    output sfh_pkg::fold_t             slot
);

    sfh_pkg::fold_t slot_reg;
    sfh_pkg::fold_t slot_next;

    sfh_pkg::kind_t kind;
    logic           addr_lt;
    logic           addr_gt;
    logic           src_left;
    logic [63:0]    l_hi;
    logic [63:0]    l_lo;
    logic [63:0]    r_hi;
    logic [63:0]    r_lo;
    logic [15:0]    l_port;
    logic [15:0]    r_port;
    logic [31:0]    port_word;

    always_comb
    begin
        case (addr_kind)
            sfh_pkg::KIND_IPV4: kind = sfh_pkg::KIND_IPV4;
            sfh_pkg::KIND_IPV6: kind = sfh_pkg::KIND_IPV6;
            default:            kind = sfh_pkg::KIND_NONE;
        endcase
    end

    // big-endian address compare, network order already matches magnitude
    always_comb
    begin
        addr_lt = 1'b0;
        addr_gt = 1'b0;
        case (kind)
            sfh_pkg::KIND_IPV4:
            begin
                addr_lt = src_addr_low[31:0] < dst_addr_low[31:0];
                addr_gt = src_addr_low[31:0] > dst_addr_low[31:0];
            end
            sfh_pkg::KIND_IPV6:
            begin
                addr_lt = {src_addr_high, src_addr_low} < {dst_addr_high, dst_addr_low};
                addr_gt = {src_addr_high, src_addr_low} > {dst_addr_high, dst_addr_low};
            end
            default:
            begin
                addr_lt = 1'b0;
                addr_gt = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        slot_next     = '0;
        slot_next.vld = vld_in;
        if (addr_lt)
            slot_next.dir = sfh_pkg::DIR_SRC_LEFT;
        else if (addr_gt)
            slot_next.dir = sfh_pkg::DIR_SRC_RIGHT;
        else if (has_ports && (sport < dport))
            slot_next.dir = sfh_pkg::DIR_SRC_LEFT;
        else if (has_ports && (sport > dport))
            slot_next.dir = sfh_pkg::DIR_SRC_RIGHT;
        else
            slot_next.dir = sfh_pkg::DIR_UNDET;

        // undetermined direction puts the destination on the left
        src_left = slot_next.dir == sfh_pkg::DIR_SRC_LEFT;
        l_hi   = src_left ? src_addr_high : dst_addr_high;
        l_lo   = src_left ? src_addr_low  : dst_addr_low;
        r_hi   = src_left ? dst_addr_high : src_addr_high;
        r_lo   = src_left ? dst_addr_low  : src_addr_low;
        l_port = src_left ? sport : dport;
        r_port = src_left ? dport : sport;
        port_word = has_ports ?
            {sfh_pkg::swap16(l_port), sfh_pkg::swap16(r_port)} : 32'd0;

        case (kind)
            sfh_pkg::KIND_IPV4:
            begin
                slot_next.n        = sfh_pkg::LabelIpv4;
                slot_next.words[0] = sfh_pkg::swap32(l_lo[31:0]);
                slot_next.words[1] = sfh_pkg::swap32(r_lo[31:0]);
                slot_next.words[2] = port_word;
                slot_next.words[3] = {24'd0, protocol};
            end
            sfh_pkg::KIND_IPV6:
            begin
                slot_next.n        = sfh_pkg::LabelIpv6;
                slot_next.words[0] = sfh_pkg::swap32(l_hi[63:32]);
                slot_next.words[1] = sfh_pkg::swap32(l_hi[31:0]);
                slot_next.words[2] = sfh_pkg::swap32(l_lo[63:32]);
                slot_next.words[3] = sfh_pkg::swap32(l_lo[31:0]);
                slot_next.words[4] = sfh_pkg::swap32(r_hi[63:32]);
                slot_next.words[5] = sfh_pkg::swap32(r_hi[31:0]);
                slot_next.words[6] = sfh_pkg::swap32(r_lo[63:32]);
                slot_next.words[7] = sfh_pkg::swap32(r_lo[31:0]);
                slot_next.words[8] = port_word;
                slot_next.words[9] = {24'd0, protocol};
            end
            default:
            begin
                slot_next.n        = sfh_pkg::LabelNone;
                slot_next.words[0] = port_word;
                slot_next.words[1] = {24'd0, protocol};
            end
        endcase
        slot_next.rem  = slot_next.n;
        slot_next.hash = sfh_pkg::HashSeed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

### hw/rtl/sfh_fold.sv
// one hash stage: while label words remain, folds label word 0 into the hash and shifts the label
// depends on sfh_pkg
`default_nettype none

module sfh_fold
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sfh_pkg::fold_t slot_in,
    output sfh_pkg::fold_t      slot_out
);

    sfh_pkg::fold_t slot_reg;
    sfh_pkg::fold_t slot_next;

    logic [sfh_pkg::HashW-1:0] h;
    logic [sfh_pkg::HashW-1:0] stepped;

    // h * 65599 = (h << 16) + (h << 6) - h, modulo 2^64
    always_comb
    begin
        h       = slot_in.hash;
        stepped = (h << 16) + (h << 6) - h
                  + {{(sfh_pkg::HashW-sfh_pkg::WordW){1'b0}}, slot_in.words[0]};
    end

    always_comb
    begin
        slot_next = slot_in;
        if (slot_in.rem != '0)
        begin
            slot_next.hash = stepped;
            slot_next.rem  = slot_in.rem - 4'd1;
            for (int i = 0; i < sfh_pkg::LabelMax - 1; i++)
            begin
                slot_next.words[i] = slot_in.words[i+1];
            end
            slot_next.words[sfh_pkg::LabelMax-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

`default_nettype wire
